// ===== design/sobm_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude block.
package sobm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 24;
  localparam int RAM_DEPTH  = 4 * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(RAM_DEPTH);
  localparam int NUM_TAPS   = 9;
  localparam int TAP_W      = 4;

  // Configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_ROUND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic tap_clear;
    logic tap_step;
    logic square;
    logic sum;
    logic root_step;
    logic round;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic emit_req;
    logic tap_last;
    logic root_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== design/sobel_edge_magnitude_rgb.sv =====
// Top level of the RGB Sobel edge magnitude block.
//
// Usage: pixels enter in raster order on the in_ stream, red in the low
// byte of in_tdata; in_tuser high marks a drain transfer, which carries no
// pixel and pulls the next pending result once the whole frame is in.
// Results leave on the out_ stream, one row and one pixel behind the input;
// out_tlast marks the result of the frame's last pixel. After the last
// pixel, send width+1 drain transfers to flush the frame.
// A transfer that causes no result leaves the input ready. One that causes
// a result runs through accept, the nine window reads through the single
// read port of the row store, squaring and summing, the bit-serial square
// root, rounding and the load into the output register, which waits while
// the output is stalled. The input is not ready during that time.
// Frame width and height are written through the cfg_ port while idle;
// a write restarts the frame. Reset (synchronous, rst_n low) sets a
// 640x480 frame and clears positions. A stalled receiver holds the result
// in the output register; the next item is still accepted meanwhile.
module sobel_edge_magnitude_rgb (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sobm_pkg::DIM_W-1:0] cfg_wdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // red_in, green_in, blue_in
  input  logic                       in_tuser,   // cmd
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,  // red_mag, green_mag, blue_mag
  output logic                       out_tlast
);
  import sobm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  sobm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sobm_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_cmd     (in_tuser),
    .in_pix     (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/sobm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sobm_ctrl.sv =====
// Controller state machine sequencing window reads, squaring, root and output.
module sobm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  sobm_pkg::dp_status_t status,
  output sobm_pkg::dp_cmd_t    cmd
);
  import sobm_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_tvalid && in_tready;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept && status.emit_req) state_nxt = ST_READ;
      ST_READ:   if (status.tap_last) state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_ROOT;
      ST_ROOT:   if (status.root_last) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_OUT;
      ST_OUT:    if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.accept    = accept;
    unique case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.tap_clear = accept && status.emit_req;
      end
      ST_READ:   cmd.tap_step  = 1'b1;
      ST_SQUARE: cmd.square    = 1'b1;
      ST_SUM:    cmd.sum       = 1'b1;
      ST_ROOT:   cmd.root_step = 1'b1;
      ST_ROUND:  cmd.round     = 1'b1;
      ST_OUT:    cmd.load      = status.out_free;
      default:   cmd.load      = 1'b0;
    endcase
  end

endmodule

// ===== design/sobm_dpath.sv =====
// Datapath: row store, positions, gradient accumulators, square root, output register.
module sobm_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [sobm_pkg::DIM_W-1:0] cfg_wdata,
  input  logic                       in_cmd,
  input  logic [23:0]                in_pix,
  input  sobm_pkg::dp_cmd_t          cmd,
  output sobm_pkg::dp_status_t       status,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,
  output logic                       out_tlast
);
  import sobm_pkg::*;

  // Tap position within the 3x3 window
  function automatic logic [1:0] tap_m(input logic [TAP_W-1:0] t);
    logic [1:0] m;
    m = 2'd2;
    if (t < TAP_W'(3)) m = 2'd0;
    else if (t < TAP_W'(6)) m = 2'd1;
    return m;
  endfunction

  function automatic logic [1:0] tap_n(input logic [TAP_W-1:0] t);
    logic [1:0] n;
    n = 2'd2;
    if (t == TAP_W'(0) || t == TAP_W'(3) || t == TAP_W'(6)) n = 2'd0;
    else if (t == TAP_W'(1) || t == TAP_W'(4) || t == TAP_W'(7)) n = 2'd1;
    return n;
  endfunction

  // Weight v by a kernel coefficient; mag2 selects 2, neg negates, zero drops
  function automatic logic signed [11:0] weigh(input logic [7:0] v, input logic zero,
                                               input logic mag2, input logic neg);
    logic signed [11:0] a;
    a = mag2 ? $signed({3'b0, v, 1'b0}) : $signed({4'b0, v});
    if (zero) a = '0;
    else if (neg) a = -a;
    return a;
  endfunction

  logic [DIM_W-1:0] fw_r, fh_r, w_eff, h_eff;
  logic [COL_W-1:0] in_col_r, out_col_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic             done_r;
  logic [TAP_W-1:0] tap_r;
  logic             vd_r, inb_d_r;
  logic [1:0]       md_r, nd_r;
  logic signed [11:0] gx_r [3];
  logic signed [11:0] gy_r [3];
  logic [19:0]      sqx_r [3];
  logic [19:0]      sqy_r [3];
  logic [15:0]      s_r [3];
  logic [2:0]       sat_r;
  logic [7:0]       root_r [3];
  logic [7:0]       res_r [3];
  logic [2:0]       bit_r;
  logic             out_tvalid_r;
  logic [23:0]      out_tdata_r;
  logic             out_tlast_r;

  logic             pix_take, col_last, row_last, frame_end;
  logic [DIM_W-1:0] rr1, cc1;
  logic [DIM_W-1:0] rr0, cc0;
  logic             inb;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [PIX_W-1:0] rdata, px;

  // Clamp dimensions into range
  always_comb begin
    w_eff = fw_r;
    if (fw_r == '0) w_eff = DIM_W'(1);
    else if (fw_r > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    h_eff = fh_r;
    if (fh_r == '0) h_eff = DIM_W'(1);
    else if (fh_r > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
  end

  assign pix_take  = !in_cmd && !done_r;
  assign col_last  = (DIM_W'(in_col_r) == w_eff - DIM_W'(1));
  assign row_last  = (DIM_W'(in_row_r) == h_eff - DIM_W'(1));
  assign frame_end = (DIM_W'(out_row_r) == h_eff - DIM_W'(1)) &&
                     (DIM_W'(out_col_r) == w_eff - DIM_W'(1));

  // Result due once the input is one row and one pixel ahead, or on a drain transfer once the frame is in
  always_comb begin
    status.emit_req  = in_cmd ? done_r :
                       (!done_r && ((in_row_r >= ROW_W'(2)) ||
                                    (in_row_r == ROW_W'(1) && in_col_r != '0)));
    status.tap_last  = (tap_r == TAP_W'(NUM_TAPS));
    status.root_last = (bit_r == 3'd0);
    status.out_free  = !out_tvalid_r || out_tready;
  end

  // Configuration, positions and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r      <= DIM_W'(640);
      fh_r      <= DIM_W'(480);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      done_r    <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) fw_r <= cfg_wdata;
      else fh_r <= cfg_wdata;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      done_r    <= 1'b0;
    end else if (cmd.load && frame_end) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      done_r    <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (DIM_W'(out_col_r) == w_eff - DIM_W'(1)) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + ROW_W'(1);
        end else begin
          out_col_r <= out_col_r + COL_W'(1);
        end
      end
      if (cmd.accept && pix_take) begin
        if (col_last) begin
          in_col_r <= '0;
          if (row_last) begin
            in_row_r <= '0;
            done_r   <= 1'b1;
          end else begin
            in_row_r <= in_row_r + ROW_W'(1);
          end
        end else begin
          in_col_r <= in_col_r + COL_W'(1);
        end
      end
    end
  end

  // Row store addressing; rows live in a ring of four
  assign waddr = {in_row_r[1:0], in_col_r};
  always_comb begin
    rr1   = DIM_W'(out_row_r) + DIM_W'(tap_m(tap_r));
    cc1   = DIM_W'(out_col_r) + DIM_W'(tap_n(tap_r));
    rr0   = rr1 - DIM_W'(1);
    cc0   = cc1 - DIM_W'(1);
    inb   = (rr1 != '0) && (rr1 <= h_eff) && (cc1 != '0) && (cc1 <= w_eff);
    raddr = {rr0[1:0], cc0[COL_W-1:0]};
  end

  sobm_ram #(.WIDTH(PIX_W), .DEPTH(RAM_DEPTH)) u_row_store (
    .clk   (clk),
    .we    (cmd.accept && pix_take),
    .waddr (waddr),
    .wdata ({in_pix[7:0], in_pix[15:8], in_pix[23:16]}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Tap sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
      vd_r  <= 1'b0;
    end else if (cmd.tap_clear) begin
      tap_r <= '0;
      vd_r  <= 1'b0;
    end else begin
      vd_r <= cmd.tap_step && (tap_r < TAP_W'(NUM_TAPS));
      if (cmd.tap_step && (tap_r < TAP_W'(NUM_TAPS))) tap_r <= tap_r + TAP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    inb_d_r <= inb;
    md_r    <= tap_m(tap_r);
    nd_r    <= tap_n(tap_r);
  end

  assign px = inb_d_r ? rdata : '0;

  // Accumulate gradients, square, sum, root, round
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [7:0] v;
      logic [7:0] t;
      logic [16:0] lim;
      v = px[16 - 8*ch +: 8];
      t = root_r[ch] | (8'd1 << bit_r);
      lim = 17'(root_r[ch] * root_r[ch]) + 17'(root_r[ch]);
      if (cmd.tap_clear) begin
        gx_r[ch] <= '0;
        gy_r[ch] <= '0;
      end else if (vd_r) begin
        gx_r[ch] <= gx_r[ch] + weigh(v, nd_r == 2'd1, md_r == 2'd1, nd_r == 2'd0);
        gy_r[ch] <= gy_r[ch] + weigh(v, md_r == 2'd1, nd_r == 2'd1, md_r == 2'd0);
      end
      if (cmd.square) begin
        sqx_r[ch] <= 20'(gx_r[ch] * gx_r[ch]);
        sqy_r[ch] <= 20'(gy_r[ch] * gy_r[ch]);
      end
      if (cmd.sum) begin
        sat_r[ch]  <= ({1'b0, sqx_r[ch]} + {1'b0, sqy_r[ch]}) >= 21'd65281;
        s_r[ch]    <= 16'(sqx_r[ch] + sqy_r[ch]);
        root_r[ch] <= '0;
      end else if (cmd.root_step) begin
        if (16'(t * t) <= s_r[ch] && 17'(t * t) < 17'd65536) root_r[ch] <= t;
      end
      if (cmd.round) begin
        if (sat_r[ch]) res_r[ch] <= 8'd255;
        else if ({1'b0, s_r[ch]} > lim) res_r[ch] <= root_r[ch] + 8'd1;
        else res_r[ch] <= root_r[ch];
      end
    end
    if (cmd.sum) bit_r <= 3'd7;
    else if (cmd.root_step) bit_r <= bit_r - 3'd1;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_tdata_r <= {res_r[2], res_r[1], res_r[0]};
      out_tlast_r <= frame_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule
